// ----- design/oidp_pkg.sv -----
package oidp_pkg;

  // group count and the wildcard value of an unwritten group
  localparam int unsigned NUM_GROUPS = 6;
  localparam logic [7:0] WILDCARD = 8'hFF;

  // group indexes; the position register holds one more than the last closed group
  localparam logic [2:0] GRP_A = 3'd0;
  localparam logic [2:0] GRP_B = 3'd1;
  localparam logic [2:0] GRP_C = 3'd2;
  localparam logic [2:0] GRP_D = 3'd3;
  localparam logic [2:0] GRP_E = 3'd4;
  localparam logic [2:0] GRP_F = 3'd5;

  // character codes
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_AMP   = 8'h26;

  // parser state carried from character to character
  typedef struct packed {
    logic [7:0]                      acc;
    logic [2:0]                      pos;
    logic [NUM_GROUPS-1:0][7:0]      groups;
    logic                            err;
  } state_t;

  // one finished result word
  typedef struct packed {
    logic [NUM_GROUPS-1:0][7:0]      groups;
    logic                            err;
  } result_t;

  localparam state_t ARM_STATE = '{
    acc:    8'h00,
    pos:    GRP_A,
    groups: {NUM_GROUPS{WILDCARD}},
    err:    1'b0
  };

endpackage

// ----- design/oidp_if.sv -----
// character channel
interface oidp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// result channel
interface oidp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] group_a;
  logic [7:0] group_b;
  logic [7:0] group_c;
  logic [7:0] group_d;
  logic [7:0] group_e;
  logic [7:0] group_f;
  logic       parse_error;

  modport source (output valid, output group_a, output group_b, output group_c,
                  output group_d, output group_e, output group_f,
                  output parse_error, input ready);
  modport sink   (input valid, input group_a, input group_b, input group_c,
                  input group_d, input group_e, input group_f,
                  input parse_error, output ready);
endinterface

// ----- design/oidp_step.sv -----
module oidp_step (
  input  oidp_pkg::state_t  state_i,
  input  logic [7:0]        char_code_i,
  input  logic              last_char_i,
  output oidp_pkg::state_t  state_o,
  output oidp_pkg::result_t result_o
);
  import oidp_pkg::*;

  state_t     nxt;
  state_t     fin;
  logic       is_digit;
  logic       do_close;
  logic [2:0] close_idx;
  logic [7:0] acc_x10;
  logic [7:0] digit;

  assign is_digit = (char_code_i >= CHAR_0) && (char_code_i <= CHAR_9);
  assign digit    = char_code_i - CHAR_0;
  // acc * 10 mod 256 as acc*8 + acc*2
  assign acc_x10  = {state_i.acc[4:0], 3'b000} + {state_i.acc[6:0], 1'b0};

  // digit accumulation, separator decode and group close
  always_comb begin
    nxt       = state_i;
    do_close  = 1'b0;
    close_idx = GRP_A;
    if (!state_i.err) begin
      if (is_digit) begin
        nxt.acc = acc_x10 + digit;
      end else if (char_code_i == CHAR_DASH && state_i.pos == GRP_A) begin
        do_close  = 1'b1;
        close_idx = GRP_A;
      end else if (char_code_i == CHAR_COLON && state_i.pos <= GRP_B) begin
        do_close  = 1'b1;
        close_idx = GRP_B;
      end else if (char_code_i == CHAR_DOT && state_i.pos <= GRP_C) begin
        do_close  = 1'b1;
        close_idx = GRP_C;
      end else if (char_code_i == CHAR_DOT && state_i.pos == GRP_D) begin
        do_close  = 1'b1;
        close_idx = GRP_D;
      end else if ((char_code_i == CHAR_STAR || char_code_i == CHAR_AMP)
                   && state_i.pos == GRP_E) begin
        do_close  = 1'b1;
        close_idx = GRP_E;
      end else begin
        nxt.err = 1'b1;
      end
    end
    if (do_close) begin
      for (int k = 0; k < NUM_GROUPS; k++) begin
        if (close_idx == 3'(k)) nxt.groups[k] = state_i.acc;
      end
      nxt.pos = close_idx + 3'd1;
      nxt.acc = 8'h00;
    end
  end

  // end of string: pending number fills the next group
  always_comb begin
    fin = nxt;
    if (!nxt.err) begin
      if (nxt.pos <= GRP_F) begin
        for (int k = 0; k < NUM_GROUPS; k++) begin
          if (nxt.pos == 3'(k)) fin.groups[k] = nxt.acc;
        end
        if (nxt.pos < GRP_D) fin.err = 1'b1;
      end else begin
        fin.err = 1'b1;
      end
    end
  end

  assign result_o.groups = fin.groups;
  assign result_o.err    = fin.err;
  assign state_o         = last_char_i ? ARM_STATE : nxt;

endmodule

// ----- design/obis_id_text_parser_unit.sv -----
// A result word is loaded into the result register as its last character leaves the
// character register. Throughput: one character per cycle; the character register
// advances each cycle, stalling only when a finished result is not taken.
// Reset (rst_ni low, asynchronous): no word held, parser state re-armed with all
// groups at the 0xFF wildcard; the same re-arm follows every result.
module obis_id_text_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  oidp_in_if.sink    in_i,
  oidp_out_if.source out_o
);
  import oidp_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       in_fire;
  state_t     state_q;
  state_t     state_d;
  result_t    res_d;
  result_t    res_q;
  logic       out_valid_q;

  // a last character may only advance when the result register is free or its word is being taken
  assign s1_fire  = s1_valid_q && (!s1_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  oidp_step u_step (
    .state_i     (state_q),
    .char_code_i (s1_char_q),
    .last_char_i (s1_last_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= in_i.char_code;
      s1_last_q <= in_i.last_char;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ARM_STATE;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.group_a     = res_q.groups[GRP_A];
  assign out_o.group_b     = res_q.groups[GRP_B];
  assign out_o.group_c     = res_q.groups[GRP_C];
  assign out_o.group_d     = res_q.groups[GRP_D];
  assign out_o.group_e     = res_q.groups[GRP_E];
  assign out_o.group_f     = res_q.groups[GRP_F];
  assign out_o.parse_error = res_q.err;

`ifndef NO_ASSERTIONS
  // a last character never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q && out_valid_q) |-> out_o.ready)
    else $error("result word overwritten");

  // the parser re-arms after every string
  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> (state_q.pos == GRP_A && state_q.acc == 8'h00
                                && !state_q.err))
    else $error("parser not re-armed after string end");

  // the position never passes group F
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos <= GRP_F)
    else $error("group position out of range");

  // a stalled last character holds the input side off
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while final character stalled");
`endif

endmodule

// ----- tb/obis_id_text_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module obis_id_text_parser_unit_tb;
  import oidp_pkg::*;

  localparam int unsigned TEXT_WORDS   = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned IDLE_PCT     = 24;

  // one row of the directed table
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  oidp_in_if  in_if ();
  oidp_out_if out_if ();

  obis_id_text_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // mirror of the parser state
  logic [7:0]                 text_acc;
  logic [2:0]                 text_pos;
  logic [NUM_GROUPS-1:0][7:0] text_groups;
  logic                       text_err;

  result_t     id_result_q[$];
  stim_row_t   stim_tbl[$];
  logic [7:0]  text_buf[$];
  int unsigned fail_cnt  = 0;
  int unsigned word_cnt  = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on;
  bit          hold_go;
  bit          hold_active;

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("ERROR: timeout after %0d cycles", cycle_cnt);
      $display("obis_id_text_parser_unit regression: fail");
      $finish;
    end
  end

  task automatic report_fail(input string msg);
    $display("ERROR: %s", msg);
    fail_cnt++;
  endtask

  function automatic result_t make_res(input logic [7:0] a, b, c, d, e, f,
                                       input logic err);
    result_t r;
    r.groups = {f, e, d, c, b, a};
    r.err    = err;
    return r;
  endfunction

  task automatic rearm_text();
    text_acc    = 8'h00;
    text_pos    = GRP_A;
    text_groups = {NUM_GROUPS{WILDCARD}};
    text_err    = 1'b0;
  endtask

  // advance the parser mirror by one character; done marks a finished id
  task automatic parse_char(input logic [7:0] ch, input logic last,
                            output bit done, output result_t res);
    bit         closing;
    logic [2:0] idx;
    closing = 1'b0;
    idx     = GRP_A;
    done    = 1'b0;
    res     = '0;
    if (!text_err) begin
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
        text_acc = text_acc * 8'd10 + (ch - CHAR_0);
      end else if (ch == CHAR_DASH && text_pos == GRP_A) begin
        closing = 1'b1;
        idx     = GRP_A;
      end else if (ch == CHAR_COLON && text_pos <= GRP_B) begin
        closing = 1'b1;
        idx     = GRP_B;
      end else if (ch == CHAR_DOT && text_pos <= GRP_D) begin
        closing = 1'b1;
        idx     = (text_pos <= GRP_C) ? GRP_C : GRP_D;
      end else if ((ch == CHAR_STAR || ch == CHAR_AMP) && text_pos == GRP_E) begin
        closing = 1'b1;
        idx     = GRP_E;
      end else begin
        text_err = 1'b1;
      end
      if (closing) begin
        text_groups[idx] = text_acc;
        text_pos         = idx + 3'd1;
        text_acc         = 8'h00;
      end
    end
    // final character: pending number fills the next group
    if (last) begin
      if (!text_err) begin
        if (text_pos <= GRP_F) begin
          text_groups[text_pos] = text_acc;
          if (text_pos < GRP_D) text_err = 1'b1;
        end else begin
          text_err = 1'b1;
        end
      end
      res.groups = text_groups;
      res.err    = text_err;
      done       = 1'b1;
      rearm_text();
    end
  endtask

  // offer one character word, predict once it is taken
  task automatic send_char(input logic [7:0] ch, input logic last,
                           input bit typed, input result_t typed_res);
    bit      done;
    bit      ignored;
    result_t res;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= ch;
    in_if.last_char <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ignored = text_err;
    parse_char(ch, last, done, res);
    if (done) id_result_q.push_back(typed ? typed_res : res);
    if (!ignored) word_cnt++;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic last, input bit typed,
                         input result_t res);
    stim_row_t row;
    row.ch    = ch;
    row.last  = last;
    row.typed = typed;
    row.res   = res;
    stim_tbl.push_back(row);
  endtask

  task automatic add_text(input string s, input bit typed, input result_t res);
    for (int i = 0; i < s.len(); i++) add_row(s[i], i == s.len() - 1, typed, res);
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(2))
      0: return 8'($urandom_range(255));
      1: begin
        case ($urandom_range(4))
          0: return CHAR_DASH;
          1: return CHAR_COLON;
          2: return CHAR_DOT;
          3: return CHAR_STAR;
          default: return CHAR_AMP;
        endcase
      end
      default: return CHAR_0 + 8'($urandom_range(9));
    endcase
  endfunction

  // 0..3 digits, mostly 1..3; three digits often wrap
  task automatic add_number();
    int n;
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(3, 1);
    repeat (n) text_buf.push_back(CHAR_0 + 8'($urandom_range(9)));
  endtask

  // mostly well-formed ids, some corrupted, cut short or pure noise
  task automatic build_text();
    int kind;
    int cut;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(8, 1)) text_buf.push_back(noise_char());
    end else begin
      if ($urandom_range(1)) begin
        add_number();
        text_buf.push_back(CHAR_DASH);
      end
      if ($urandom_range(1)) begin
        add_number();
        text_buf.push_back(CHAR_COLON);
      end
      add_number();
      text_buf.push_back(CHAR_DOT);
      add_number();
      if ($urandom_range(3) != 0) begin
        text_buf.push_back(CHAR_DOT);
        add_number();
        if ($urandom_range(3) != 0) begin
          text_buf.push_back($urandom_range(1) ? CHAR_STAR : CHAR_AMP);
          add_number();
        end
      end
      if (kind < 24) begin
        text_buf[$urandom_range(text_buf.size() - 1)] = noise_char();
      end else if (kind < 32) begin
        cut = $urandom_range(text_buf.size(), 1);
        while (text_buf.size() > cut) text_buf.delete(text_buf.size() - 1);
      end
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
  endtask

  task automatic check_result();
    result_t    want;
    logic [7:0] got [NUM_GROUPS];
    if (id_result_q.size() == 0) begin
      report_fail("result word with nothing expected");
    end else begin
      want   = id_result_q.pop_front();
      got[0] = out_if.group_a;
      got[1] = out_if.group_b;
      got[2] = out_if.group_c;
      got[3] = out_if.group_d;
      got[4] = out_if.group_e;
      got[5] = out_if.group_f;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        if (got[g] !== want.groups[g])
          report_fail($sformatf("group %c: got %0d, want %0d",
                                8'd65 + 8'(g), got[g], want.groups[g]));
      end
      if (out_if.parse_error !== want.err)
        report_fail($sformatf("parse_error: got %b, want %b",
                              out_if.parse_error, want.err));
    end
  endtask

  // result side: check taken words, random ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) check_result();
      out_if.ready <= !hold_active && (!idle_on || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = 8'h00;
    in_if.last_char = 1'b0;
    out_if.ready    = 1'b0;
    idle_on         = 1'b1;
    hold_go         = 1'b0;
    rearm_text();

    // directed: lone number, full id with wrap, '&' form, misplaced '-',
    // bad characters at both code extremes
    add_text("5", 1'b1, make_res(8'd5, WILDCARD, WILDCARD, WILDCARD, WILDCARD,
                                 WILDCARD, 1'b1));
    add_text("9-9:1.8.999*255", 1'b0, '0);
    add_text("1.2.3&4", 1'b0, '0);
    add_text("3:-", 1'b1, make_res(WILDCARD, 8'd3, WILDCARD, WILDCARD, WILDCARD,
                                   WILDCARD, 1'b1));
    add_row(CHAR_0 + 8'd7, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, make_res(WILDCARD, WILDCARD, WILDCARD, WILDCARD,
                                        WILDCARD, WILDCARD, 1'b1));
    add_row(CHAR_0 + 8'd1, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, make_res(WILDCARD, WILDCARD, WILDCARD, WILDCARD,
                                        WILDCARD, WILDCARD, 1'b1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_tbl[i])
      send_char(stim_tbl[i].ch, stim_tbl[i].last, stim_tbl[i].typed, stim_tbl[i].res);

    // sender waits for every pending result
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (id_result_q.size() != 0);

    // random ids: hold-off window, then a stretch with no idling
    word_cnt = 0;
    while (word_cnt < TEXT_WORDS) begin
      if (word_cnt >= 700) hold_go = 1'b1;
      idle_on = !(word_cnt >= 1000 && word_cnt < 1400);
      build_text();
      send_text();
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (id_result_q.size() != 0);
    repeat (4) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("obis_id_text_parser_unit regression: pass");
    end else begin
      $display("obis_id_text_parser_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/oidp_pkg.sv
design/oidp_if.sv
design/oidp_step.sv
design/obis_id_text_parser_unit.sv
tb/obis_id_text_parser_unit_tb.sv
